@@ rtl/deq_pkg.sv @@
// Shared types and operation codes for the double-ended queue unit.
// No dependencies; imported by double_ended_queue_unit.
package deq_pkg;

   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [1:0]               opcode_type;

   // Request operation codes
   localparam opcode_type OP_PUSH_FRONT = 2'd0;
   localparam opcode_type OP_PUSH_BACK  = 2'd1;
   localparam opcode_type OP_REMOVE     = 2'd2;
   localparam opcode_type OP_DUMP       = 2'd3;

endpackage

@@ rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed words kept as a ring buffer in one
// synchronous memory, with a read-out sequencer for dumps.
// Depends on deq_pkg (types, operation codes).
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_opcode, req_value
//   rsp     | out       | rsp_valid / rsp_stall | rsp_value_res, rsp_backward,
//           |           |                       | rsp_empty_res, rsp_last
//
// Push and remove requests are taken back to back; only a dump stalls requests.
// A dump holds req_stall while it reads out two results per entry (one when empty);
// the memory's single read port delivers one result per cycle unless rsp_stall holds.
// rsp_stall freezes the read sequencer; the registered read data is the
// output stage. Reset clears the control registers only: storage is not
// cleared and needs no clearing pass.
module double_ended_queue_unit
   import deq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  opcode_type req_opcode,
   input  word_type   req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output word_type   rsp_value_res,
   output logic       rsp_backward,
   output logic       rsp_empty_res,
   output logic       rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W   = (IW+1)'(DEPTH);
   localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic          state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] off_ff,   off_in;
   logic          bwd_ff,   bwd_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_bwd_ff, rsp_empty_ff, rsp_last_ff;
   word_type      rd_data_ff;

   word_type      mem [DEPTH];

   logic          req_accept, issue, full, is_empty, off_is_end;
   logic [IW-1:0] slot_off, slot, front_dec, wr_addr;
   logic [IW:0]   slot_sum;
   logic          wr_en;

   assign req_stall  = (state_ff == ST_DUMP);
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == FULL_CNT);
   assign is_empty   = (count_ff == '0);
   assign off_is_end = (CW'(off_ff) == count_ff - CW'(1));

   // a read goes out when the output stage is free or being emptied
   assign issue = (state_ff == ST_DUMP) && (!rsp_valid_ff || !rsp_stall);

   // ring slot = front + offset, wrapped with one compare and subtract
   always_comb begin
      if (state_ff == ST_DUMP) begin
         slot_off = off_ff;
      end else if (req_opcode == OP_PUSH_BACK) begin
         slot_off = count_ff[IW-1:0];
      end else begin
         slot_off = IW'(1);
      end
      slot_sum = {1'b0, front_ff} + {1'b0, slot_off};
      if (slot_sum >= DEPTH_W) begin
         slot = IW'(slot_sum - DEPTH_W);
      end else begin
         slot = slot_sum[IW-1:0];
      end
   end

   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - IW'(1);

   assign wr_en   = req_accept && !full &&
                    ((req_opcode == OP_PUSH_FRONT) || (req_opcode == OP_PUSH_BACK));
   assign wr_addr = (req_opcode == OP_PUSH_FRONT) ? front_dec : slot;

   // pointer, count and sequencer next state
   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      off_in   = off_ff;
      bwd_in   = bwd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_PUSH_FRONT: begin
                     if (!full) begin
                        front_in = front_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (!full) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff >= CW'(2)) begin
                        front_in = slot;
                        count_in = count_ff - CW'(2);
                     end else begin
                        count_in = '0;
                     end
                  end
                  default: begin
                     state_in = ST_DUMP;
                     off_in   = '0;
                     bwd_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (issue) begin
               if (is_empty) begin
                  state_in = ST_IDLE;
               end else if (!bwd_ff) begin
                  if (off_is_end) begin
                     bwd_in = 1'b1;
                  end else begin
                     off_in = off_ff + IW'(1);
                  end
               end else if (off_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  off_in = off_ff - IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = issue || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         off_ff       <= '0;
         bwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         off_ff       <= off_in;
         bwd_ff       <= bwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (issue) begin
         rd_data_ff <= mem[slot];
      end
   end

   // result flags travel alongside the read data
   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_bwd_ff   <= bwd_ff;
         rsp_empty_ff <= is_empty;
         rsp_last_ff  <= is_empty || (bwd_ff && (off_ff == '0));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_empty_ff ? word_type'(0) : rd_data_ff;
   assign rsp_backward  = rsp_bwd_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(issue && rsp_valid_ff && rsp_stall))
      else $error("read issued over a stalled result");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_last && !rsp_backward))
      else $error("empty result not a lone final result");

   a_dump_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && $past(state_ff == ST_DUMP))
         |-> ($stable(front_ff) && $stable(count_ff)))
      else $error("queue pointers moved during a dump");

endmodule

@@ tb/sv/deque_result_checker.sv @@
// Result checker for double_ended_queue_unit: mirrors the queue contents from
// accepted requests and compares every dump result with the mirrored words.
// Depends on deq_pkg (word and opcode types, operation codes).
module deque_result_checker
   import deq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  opcode_type req_opcode,
   input  word_type   req_value,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  word_type   rsp_value_res,
   input  logic       rsp_backward,
   input  logic       rsp_empty_res,
   input  logic       rsp_last,
   output int         errors,
   output int         pending
);

   localparam int SLOT_W = $clog2(DEPTH);

   typedef struct packed {
      word_type word;
      logic     backward;
      logic     empty;
      logic     last;
   } dump_result_type;

   // Mirror of the ring buffer
   word_type          slots [DEPTH];
   logic [SLOT_W-1:0] head_slot;
   int                fill_count;

   // Dump results still to come, oldest first
   dump_result_type   dump_due [$];
   int                results_seen;

   function automatic logic [SLOT_W-1:0] slot_at(input int offset);
      return SLOT_W'((int'(head_slot) + offset) % DEPTH);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("dump result %0d: %s is %h, should be %h", results_seen, field, got, want);
      errors++;
   endtask

   task automatic due_result(input word_type word, input logic backward,
                             input logic empty, input logic last);
      dump_result_type item;
      item.word     = word;
      item.backward = backward;
      item.empty    = empty;
      item.last     = last;
      dump_due.push_back(item);
   endtask

   // Update the mirror for one accepted request and queue any dump results
   task automatic apply_deque_request(input opcode_type op, input word_type word);
      int i;
      case (op)
         OP_PUSH_FRONT: begin
            if (fill_count < DEPTH) begin
               head_slot        = slot_at(DEPTH - 1);
               slots[head_slot] = word;
               fill_count       = fill_count + 1;
            end
         end
         OP_PUSH_BACK: begin
            if (fill_count < DEPTH) begin
               slots[slot_at(fill_count)] = word;
               fill_count = fill_count + 1;
            end
         end
         OP_REMOVE: begin
            // two or more: both ends go; one: queue empties, head stays
            if (fill_count >= 2) begin
               head_slot  = slot_at(1);
               fill_count = fill_count - 2;
            end else begin
               fill_count = 0;
            end
         end
         OP_DUMP: begin
            if (fill_count == 0) begin
               due_result('0, 1'b0, 1'b1, 1'b1);
            end else begin
               for (i = 0; i < fill_count; i++)
                  due_result(slots[slot_at(i)], 1'b0, 1'b0, 1'b0);
               for (i = fill_count; i > 0; i--)
                  due_result(slots[slot_at(i - 1)], 1'b1, 1'b0, i == 1);
            end
         end
      endcase
   endtask

   // Requests first, so a result in the same cycle still finds its entry
   always @(posedge clock) begin
      dump_result_type want;
      if (reset) begin
         head_slot  = '0;
         fill_count = 0;
         dump_due.delete();
      end else begin
         if (req_valid && !req_stall)
            apply_deque_request(req_opcode, req_value);
         if (rsp_valid && !rsp_stall) begin
            if (dump_due.size() == 0) begin
               report_mismatch("unexpected result, value", rsp_value_res, '0);
            end else begin
               want = dump_due.pop_front();
               if (rsp_value_res !== want.word)
                  report_mismatch("value_res", rsp_value_res, want.word);
               if (rsp_backward !== want.backward)
                  report_mismatch("backward", 32'(rsp_backward), 32'(want.backward));
               if (rsp_empty_res !== want.empty)
                  report_mismatch("empty_res", 32'(rsp_empty_res), 32'(want.empty));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
            results_seen++;
         end
      end
      pending = dump_due.size();
   end

endmodule

@@ tb/sv/tb_double_ended_queue_unit.sv @@
// Testbench top for double_ended_queue_unit: drives directed and random
// requests with random idling and hands checking to deque_result_checker.
// Depends on deq_pkg, double_ended_queue_unit and deque_result_checker.
module tb_double_ended_queue_unit;
   import deq_pkg::*;

   localparam int DEPTH           = 32;
   localparam int RANDOM_REQUESTS = 310;
   localparam int CALM_TAIL       = 40;
   localparam int SETTLE_CYCLES   = 4 * DEPTH + 16;
   localparam int CYCLE_LIMIT     = 1_500_000;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   opcode_type req_opcode = OP_DUMP;
   word_type   req_value  = '0;
   logic       rsp_valid;
   logic       rsp_stall  = 1'b0;
   word_type   rsp_value_res;
   logic       rsp_backward;
   logic       rsp_empty_res;
   logic       rsp_last;

   int   mismatches;
   int   results_due;
   int   cycle_count   = 0;
   int   requests_sent = 0;
   int   stall_left    = 0;
   int   flow_left     = 0;
   logic calm          = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_res (rsp_value_res),
      .rsp_backward  (rsp_backward),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

   deque_result_checker #(.DEPTH(DEPTH)) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_res (rsp_value_res),
      .rsp_backward  (rsp_backward),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last),
      .errors        (mismatches),
      .pending       (results_due)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side stalls in random bursts, none in the calm tail
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (flow_left > 0) begin
         flow_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         flow_left = $urandom_range(0, 30);
         rsp_stall <= 1'b0;
      end
   end

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return word_type'($urandom());
      endcase
   endfunction

   function automatic opcode_type random_push();
      return ($urandom_range(0, 1) == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
   endfunction

   // Stall is looked at mid-cycle, when it has settled
   task automatic send_request(input opcode_type op, input word_type word);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= word;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      requests_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Hold off new requests until every dump result has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      @(posedge clock);
   endtask

   task automatic random_sequence();
      int kind;
      int n;
      int pick;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         // fill towards full, then read it all back
         n = $urandom_range(20, 40);
         repeat (n) send_request(random_push(), random_word());
         send_request(OP_DUMP, random_word());
      end else if (kind < 5) begin
         // drain
         n = $urandom_range(1, 18);
         repeat (n) send_request(OP_REMOVE, random_word());
         if ($urandom_range(0, 1) == 1)
            send_request(OP_DUMP, random_word());
      end else if (kind < 9) begin
         // mixed traffic, push-heavy
         n = $urandom_range(4, 16);
         repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick < 11)
               send_request(random_push(), random_word());
            else if (pick < 16)
               send_request(OP_REMOVE, random_word());
            else
               send_request(OP_DUMP, random_word());
         end
      end else begin
         // noise
         n = $urandom_range(2, 8);
         repeat (n) send_request(opcode_type'($urandom_range(0, 3)), word_type'($urandom()));
      end
   endtask

   initial begin
      int   random_start;
      logic paused;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: dump and remove
      send_request(OP_DUMP, '0);
      send_request(OP_REMOVE, '1);
      // Extremes at both ends
      send_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(OP_PUSH_BACK, 32'sh8000_0000);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_DUMP, 32'sh5555_5555);
      // Remove with several entries, then down to empty
      send_request(OP_REMOVE, '0);
      send_request(OP_DUMP, '0);
      send_request(OP_REMOVE, '0);
      send_request(OP_DUMP, '0);
      // Remove with a single entry leaves the head where it was
      send_request(OP_PUSH_BACK, 32'sh5555_5555);
      send_request(OP_REMOVE, '0);
      send_request(OP_DUMP, '0);
      send_request(OP_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(OP_REMOVE, '0);
      send_request(OP_PUSH_BACK, 32'sh0000_0001);
      send_request(OP_PUSH_FRONT, 32'sh0000_0002);
      send_request(OP_DUMP, '0);
      send_request(OP_REMOVE, '0);
      send_request(OP_DUMP, '0);
      wait_drained();

      // Fill past full so pushes are dropped, with wrap round the ring
      random_start = requests_sent;
      repeat (DEPTH + 4) send_request(random_push(), random_word());
      send_request(OP_DUMP, random_word());

      while (requests_sent - random_start < RANDOM_REQUESTS) begin
         if (!calm && requests_sent - random_start >= RANDOM_REQUESTS - CALM_TAIL)
            calm <= 1'b1;
         if (!paused && requests_sent - random_start >= RANDOM_REQUESTS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         random_sequence();
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
